@@ sv/wmsd_pkg.sv @@
// Shared types and constants for the weighted mean / standard deviation unit.
`default_nettype none

package wmsd_pkg;

  localparam logic [16:0]        MaxSamples = 17'd65536;
  localparam logic signed [15:0] OneQ88     = 16'sd256;
  localparam int                 CntW       = 6;
  localparam int                 DivSteps   = 64;
  localparam int                 SqrtSteps  = 32;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_FLUSH,
    ST_DIV_MEAN,
    ST_MEAN_FIX,
    ST_DIV_EX2,
    ST_VAR,
    ST_SQRT,
    ST_FINISH
  } wmsd_state_e;

  typedef struct packed {
    logic accept;
    logic div_load;
    logic div_sel_ex2;
    logic div_step;
    logic mean_fix;
    logic var_calc;
    logic sqrt_step;
    logic load_out;
  } wmsd_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic wsum_pos;
  } wmsd_status_t;

endpackage

`default_nettype wire

@@ sv/wmsd_if.sv @@
// Request channel interfaces: sample input and statistics result.
`default_nettype none

interface wmsd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic signed [15:0] weight;
  logic               last;

  modport source (output valid, output sample, output weight, output last, input ready);
  modport sink   (input valid, input sample, input weight, input last, output ready);
endinterface

interface wmsd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mean_value;
  logic [15:0]        std_dev;
  logic               weight_ok;
  logic               saturated;

  modport source (output valid, output mean_value, output std_dev, output weight_ok,
                  output saturated, input ready);
  modport sink   (input valid, input mean_value, input std_dev, input weight_ok,
                  input saturated, output ready);
endinterface

`default_nettype wire

@@ sv/wmsd_ctrl.sv @@
// Controller: run sequencing, divide/sqrt step counting, result register valid.
`default_nettype none

module wmsd_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  in_last_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire wmsd_pkg::wmsd_status_t status_i,
  output wmsd_pkg::wmsd_cmd_t        cmd_o
);

  wmsd_pkg::wmsd_state_e         state_q, state_d;
  logic [wmsd_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wmsd_pkg::ST_ACCUM;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      wmsd_pkg::ST_ACCUM: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = wmsd_pkg::ST_FLUSH;
        end
      end
      wmsd_pkg::ST_FLUSH: begin
        if (!status_i.pipe_busy) begin
          cnt_d = '0;
          if (status_i.wsum_pos) begin
            cmd_o.div_load = 1'b1;
            state_d        = wmsd_pkg::ST_DIV_MEAN;
          end else begin
            state_d = wmsd_pkg::ST_FINISH;
          end
        end
      end
      wmsd_pkg::ST_DIV_MEAN: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == wmsd_pkg::CntW'(wmsd_pkg::DivSteps - 1)) begin
          state_d = wmsd_pkg::ST_MEAN_FIX;
        end
      end
      wmsd_pkg::ST_MEAN_FIX: begin
        cmd_o.mean_fix    = 1'b1;
        cmd_o.div_load    = 1'b1;
        cmd_o.div_sel_ex2 = 1'b1;
        cnt_d             = '0;
        state_d           = wmsd_pkg::ST_DIV_EX2;
      end
      wmsd_pkg::ST_DIV_EX2: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == wmsd_pkg::CntW'(wmsd_pkg::DivSteps - 1)) begin
          state_d = wmsd_pkg::ST_VAR;
        end
      end
      wmsd_pkg::ST_VAR: begin
        cmd_o.var_calc = 1'b1;
        cnt_d          = '0;
        state_d        = wmsd_pkg::ST_SQRT;
      end
      wmsd_pkg::ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == wmsd_pkg::CntW'(wmsd_pkg::SqrtSteps - 1)) begin
          state_d = wmsd_pkg::ST_FINISH;
        end
      end
      wmsd_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = wmsd_pkg::ST_ACCUM;
        end
      end
      default: begin
        state_d = wmsd_pkg::ST_ACCUM;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ sv/wmsd_dp.sv @@
// Datapath: multiply/accumulate pipeline, shared restoring divider, bitwise isqrt.
`default_nettype none

module wmsd_dp (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_data_i,
  input  wire logic signed [15:0]     sample_i,
  input  wire logic signed [15:0]     weight_i,
  input  wire wmsd_pkg::wmsd_cmd_t    cmd_i,
  output wmsd_pkg::wmsd_status_t      status_o,
  output logic signed [15:0]          mean_value_o,
  output logic [15:0]                 std_dev_o,
  output logic                        weight_ok_o,
  output logic                        saturated_o
);

  logic               mode_q;
  logic [16:0]        count_q;
  logic               keep;

  logic               v1_q, v2_q;
  logic signed [15:0] x1_q, w1_q, w2_q;
  logic signed [31:0] wx1_q;
  logic signed [47:0] wxx2_q;
  logic signed [31:0] wx2_q;

  logic signed [47:0] sum_w_q;
  logic signed [63:0] sum_wsq_q;
  logic signed [33:0] sum_wt_q;
  logic               wsum_pos;

  logic [63:0]        quo_q;
  logic [33:0]        rem_q;
  logic               neg_q;
  logic [63:0]        num;
  logic [34:0]        div_sh;
  logic [35:0]        div_diff;

  logic signed [15:0] mean_q;
  logic               mean_sat_q;
  logic signed [31:0] msq_q;
  logic signed [63:0] ex2;
  logic signed [64:0] var65;

  logic [63:0]        sq_v_q, sq_res_q, sq_bit_q;
  logic [63:0]        sq_t;

  logic               sd_big;
  logic               clip;

  assign keep     = count_q < wmsd_pkg::MaxSamples;
  assign wsum_pos = !sum_wt_q[33] && (sum_wt_q != '0);
  assign status_o.pipe_busy = v1_q || v2_q;
  assign status_o.wsum_pos  = wsum_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // multiply pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.accept && keep;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x1_q  <= sample_i;
      w1_q  <= mode_q ? weight_i : wmsd_pkg::OneQ88;
      wx1_q <= 32'(mode_q ? weight_i : wmsd_pkg::OneQ88) * 32'(sample_i);
    end
    if (v1_q) begin
      w2_q   <= w1_q;
      wx2_q  <= wx1_q;
      wxx2_q <= 48'(wx1_q) * 48'(x1_q);
    end
  end

  // accumulators and sample count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_w_q   <= '0;
      sum_wsq_q <= '0;
      sum_wt_q  <= '0;
      count_q   <= '0;
    end else if (cmd_i.load_out) begin
      sum_w_q   <= '0;
      sum_wsq_q <= '0;
      sum_wt_q  <= '0;
      count_q   <= '0;
    end else begin
      if (v2_q) begin
        sum_w_q   <= sum_w_q + 48'(wx2_q);
        sum_wsq_q <= sum_wsq_q + 64'(wxx2_q);
        sum_wt_q  <= sum_wt_q + 34'(w2_q);
      end
      if (cmd_i.accept) begin
        count_q <= keep ? count_q + 17'd1 : wmsd_pkg::MaxSamples + 17'd1;
      end
    end
  end

  // restoring divider, magnitude of dividend over positive weight sum
  always_comb begin
    num      = cmd_i.div_sel_ex2 ? sum_wsq_q : 64'(sum_w_q);
    div_sh   = {rem_q, quo_q[63]};
    div_diff = {1'b0, div_sh} - {2'b00, sum_wt_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      neg_q <= num[63];
      quo_q <= num[63] ? -num : num;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!div_diff[35]) begin
        rem_q <= div_diff[33:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= div_sh[33:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  // mean sign and clip, then its square
  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_fix) begin
      if (!neg_q) begin
        if (quo_q > 64'd32767) begin
          mean_q     <= 16'sh7fff;
          mean_sat_q <= 1'b1;
        end else begin
          mean_q     <= quo_q[15:0];
          mean_sat_q <= 1'b0;
        end
      end else begin
        if (quo_q > 64'd32768) begin
          mean_q     <= 16'sh8000;
          mean_sat_q <= 1'b1;
        end else begin
          mean_q     <= -quo_q[15:0];
          mean_sat_q <= 1'b0;
        end
      end
    end
    msq_q <= 32'(mean_q) * 32'(mean_q);
  end

  always_comb begin
    ex2   = neg_q ? -quo_q : quo_q;
    var65 = {ex2[63], ex2} - 65'(msq_q);
    sq_t  = sq_res_q + sq_bit_q;
  end

  // integer square root, two bits of radicand per step
  always_ff @(posedge clk_i) begin
    if (cmd_i.var_calc) begin
      sq_v_q   <= var65[64] ? '0 : var65[63:0];
      sq_res_q <= '0;
      sq_bit_q <= 64'h4000_0000_0000_0000;
    end else if (cmd_i.sqrt_step) begin
      if (sq_v_q >= sq_t) begin
        sq_v_q   <= sq_v_q - sq_t;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
  end

  // result register
  assign sd_big = sq_res_q > 64'd65535;
  assign clip   = count_q > wmsd_pkg::MaxSamples;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      mean_value_o <= wsum_pos ? mean_q : '0;
      std_dev_o    <= !wsum_pos ? '0 : (sd_big ? 16'hffff : sq_res_q[15:0]);
      weight_ok_o  <= wsum_pos;
      saturated_o  <= clip || (wsum_pos && (mean_sat_q || sd_big));
    end
  end

endmodule

`default_nettype wire

@@ sv/weighted_mean_std_dev_unit.sv @@
// Top level of the weighted mean and standard deviation unit.
// Samples of a run are taken one per cycle and accumulated through a two-stage
// multiply pipeline. After the item flagged last, input is held off while the
// pipeline drains, the mean is divided in the one-bit-per-cycle restoring divider,
// its sign is fixed, E[x^2] is divided, the variance is formed, the bitwise square
// root runs and the result is loaded; a run whose weight sum is not positive
// skips from the drain straight to the result load.
// The result sits in an output register, so the next run starts while it waits.
// weighted_mode resets to 1 and is written through cfg_we_i/cfg_data_i.
`default_nettype none

module weighted_mean_std_dev_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire logic   cfg_data_i,
  wmsd_in_if.sink     in_i,
  wmsd_out_if.source  out_o
);

  wmsd_pkg::wmsd_cmd_t    cmd;
  wmsd_pkg::wmsd_status_t status;

  wmsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_last_i   (in_i.last),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wmsd_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .sample_i     (in_i.sample),
    .weight_i     (in_i.weight),
    .cmd_i        (cmd),
    .status_o     (status),
    .mean_value_o (out_o.mean_value),
    .std_dev_o    (out_o.std_dev),
    .weight_ok_o  (out_o.weight_ok),
    .saturated_o  (out_o.saturated)
  );

endmodule

`default_nettype wire

@@ bench/weighted_mean_std_dev_unit_tb.sv @@
// Testbench for weighted_mean_std_dev_unit: directed rows and random runs vs predictor.
`timescale 1ns / 100ps

module weighted_mean_std_dev_unit_tb;

  localparam int CycleLimit   = 1_000_000;
  localparam int SettleCycles = 200;

  typedef struct packed {
    logic signed [15:0] mean;
    logic [15:0]        sd;
    logic               ok;
    logic               sat;
  } stats_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic signed [15:0] weight;
    logic               last;
    logic               mode;
    logic               typed;
    stats_t             exp;
  } dir_row_t;

  localparam stats_t NoStats = '{16'sd0, 16'd0, 1'b0, 1'b0};

  localparam int DirRows = 22;
  localparam dir_row_t DirTab [DirRows] = '{
    '{16'sd256,    16'sd256,    1'b1, 1'b1, 1'b1, '{16'sd256, 16'd0, 1'b1, 1'b0}},
    '{16'sd32767,  16'sd0,      1'b1, 1'b1, 1'b1, NoStats},
    '{-16'sd32768, -16'sd32768, 1'b1, 1'b1, 1'b1, NoStats},
    '{16'sd100,    16'sd512,    1'b0, 1'b1, 1'b0, NoStats},
    '{-16'sd5,     -16'sd512,   1'b1, 1'b1, 1'b1, NoStats},
    '{16'sd32767,  16'sd256,    1'b0, 1'b1, 1'b0, NoStats},
    '{16'sd0,      -16'sd255,   1'b1, 1'b1, 1'b1, '{16'sd32767, 16'd65535, 1'b1, 1'b1}},
    '{-16'sd32768, 16'sd256,    1'b0, 1'b1, 1'b0, NoStats},
    '{16'sd0,      -16'sd255,   1'b1, 1'b1, 1'b1, '{-16'sd32768, 16'd65535, 1'b1, 1'b1}},
    '{16'sd32767,  16'sd32767,  1'b1, 1'b1, 1'b1, '{16'sd32767, 16'd0, 1'b1, 1'b0}},
    '{-16'sd32768, 16'sd1,      1'b1, 1'b1, 1'b1, '{-16'sd32768, 16'd0, 1'b1, 1'b0}},
    '{16'sd512,    16'sd256,    1'b0, 1'b1, 1'b0, NoStats},
    '{-16'sd512,   16'sd256,    1'b1, 1'b1, 1'b0, NoStats},
    '{-16'sd300,   16'sd700,    1'b0, 1'b1, 1'b0, NoStats},
    '{16'sd1234,   -16'sd200,   1'b0, 1'b1, 1'b0, NoStats},
    '{-16'sd7,     16'sd300,    1'b1, 1'b1, 1'b0, NoStats},
    '{16'sd1000,   -16'sd32768, 1'b0, 1'b0, 1'b0, NoStats},
    '{-16'sd999,   16'sd0,      1'b0, 1'b0, 1'b0, NoStats},
    '{16'sd32767,  -16'sd1,     1'b1, 1'b0, 1'b0, NoStats},
    '{-16'sd32768, 16'sd12345,  1'b1, 1'b0, 1'b0, NoStats},
    '{-16'sd1,     -16'sd1,     1'b0, 1'b1, 1'b0, NoStats},
    '{16'sd1,      16'sd32767,  1'b1, 1'b1, 1'b0, NoStats}
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_data_i;

  wmsd_in_if  smp_if ();
  wmsd_out_if res_if ();

  weighted_mean_std_dev_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (smp_if),
    .out_o      (res_if)
  );

  // predictor state
  logic   weighted_q;
  longint acc_wx;
  longint acc_wxx;
  longint acc_w;
  int     acc_count;

  stats_t pending_stats [$];
  int     err_cnt;
  int     src_pct;
  int     rcv_pct;
  int     cycle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("weighted_mean_std_dev_unit verification failed");
      $finish;
    end
  end

  function automatic logic [63:0] isqrt_u64(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] b;
    logic [63:0] rem;
    root = '0;
    b    = 64'h4000_0000_0000_0000;
    rem  = v;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic bit stats_accumulate(input logic signed [15:0] x_in, w_in,
                                          input logic lst, output stats_t res);
    longint      x;
    longint      w;
    longint      wx;
    longint      mean;
    longint      ex2;
    longint      variance;
    logic [63:0] root;
    bit          sat;
    x   = longint'(x_in);
    w   = weighted_q ? longint'(w_in) : longint'(wmsd_pkg::OneQ88);
    sat = 1'b0;
    res = NoStats;
    if (acc_count < int'(wmsd_pkg::MaxSamples)) begin
      wx = w * x;
      acc_wx  += wx;
      acc_wxx += wx * x;
      acc_w   += w;
      acc_count++;
    end else begin
      acc_count = int'(wmsd_pkg::MaxSamples) + 1;
    end
    if (!lst) return 1'b0;
    if (acc_count > int'(wmsd_pkg::MaxSamples)) sat = 1'b1;
    if (acc_w > 0) begin
      res.ok = 1'b1;
      mean = acc_wx / acc_w;
      if (mean > 32767) begin
        mean = 32767;
        sat  = 1'b1;
      end else if (mean < -32768) begin
        mean = -32768;
        sat  = 1'b1;
      end
      ex2      = acc_wxx / acc_w;
      variance = ex2 - mean * mean;
      if (variance < 0) variance = 0;
      root = isqrt_u64(variance);
      if (root > 64'd65535) begin
        root = 64'd65535;
        sat  = 1'b1;
      end
      res.mean = mean[15:0];
      res.sd   = root[15:0];
    end
    res.sat   = sat;
    acc_wx    = 0;
    acc_wxx   = 0;
    acc_w     = 0;
    acc_count = 0;
    return 1'b1;
  endfunction

  task automatic check_result();
    stats_t got;
    stats_t want;
    got = '{res_if.mean_value, res_if.std_dev, res_if.weight_ok, res_if.saturated};
    if (pending_stats.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("unexpected result: mean %0d sd %0d ok %0b sat %0b",
                 got.mean, got.sd, got.ok, got.sat);
    end else begin
      want = pending_stats.pop_front();
      if (got.mean !== want.mean || got.sd !== want.sd ||
          got.ok !== want.ok || got.sat !== want.sat) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("mismatch: mean %0d/%0d sd %0d/%0d ok %0b/%0b sat %0b/%0b (exp/got)",
                   want.mean, got.mean, want.sd, got.sd, want.ok, got.ok,
                   want.sat, got.sat);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) check_result();
    res_if.ready <= ($urandom_range(99) >= rcv_pct);
  end

  // one request on the sample channel; valid stays high on return
  task automatic push_sample(input logic signed [15:0] x, w, input logic lst,
                             input bit use_typed, input stats_t typed_exp);
    stats_t res;
    while ($urandom_range(99) < src_pct) begin
      smp_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= x;
    smp_if.weight <= w;
    smp_if.last   <= lst;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
    if (stats_accumulate(x, w, lst, res))
      pending_stats.push_back(use_typed ? typed_exp : res);
  endtask

  task automatic set_weighted_mode(input logic m);
    smp_if.valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    weighted_q = m;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'sd32767;
      1:       return -16'sd32768;
      2, 3:    return 16'($urandom_range(511)) - 16'sd256;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic signed [15:0] pick_weight();
    case ($urandom_range(9))
      0:       return 16'sd0;
      1:       return 16'($urandom());
      2:       return 16'sd256;
      3:       return 16'sd32767;
      default: return 16'($urandom_range(32767, 1));
    endcase
  endfunction

  task automatic run_random_phase(input int n_items, input logic m, input int s_pct,
                                  input int r_pct);
    int sent;
    int len;
    set_weighted_mode(m);
    src_pct = s_pct;
    rcv_pct = r_pct;
    sent    = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      for (int i = 0; i < len; i++)
        push_sample(pick_sample(), pick_weight(), i == len - 1, 1'b0, NoStats);
      sent += len;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = 1'b0;
    smp_if.valid  = 1'b0;
    smp_if.sample = '0;
    smp_if.weight = '0;
    smp_if.last   = 1'b0;
    res_if.ready  = 1'b0;
    weighted_q    = 1'b1;
    acc_wx        = 0;
    acc_wxx       = 0;
    acc_w         = 0;
    acc_count     = 0;
    err_cnt       = 0;
    src_pct       = 0;
    rcv_pct       = 0;
    cycle_cnt     = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // first row runs on the reset value of weighted_mode
    for (int r = 0; r < DirRows; r++) begin
      if (r > 0 && DirTab[r].mode != weighted_q) set_weighted_mode(DirTab[r].mode);
      push_sample(DirTab[r].sample, DirTab[r].weight, DirTab[r].last,
                  DirTab[r].typed, DirTab[r].exp);
    end

    run_random_phase(80, 1'b1, 0, 0);
    run_random_phase(80, 1'b0, 45, 0);
    run_random_phase(80, 1'b1, 0, 45);
    run_random_phase(80, 1'b0, 35, 35);
    run_random_phase(80, 1'b1, 45, 0);
    run_random_phase(80, 1'b1, 35, 35);
    run_random_phase(80, 1'b0, 0, 45);
    run_random_phase(80, 1'b0, 0, 0);

    smp_if.valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("weighted_mean_std_dev_unit verification clean");
    end else begin
      $display("weighted_mean_std_dev_unit verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/wmsd_pkg.sv
sv/wmsd_if.sv
sv/wmsd_ctrl.sv
sv/wmsd_dp.sv
sv/weighted_mean_std_dev_unit.sv
bench/weighted_mean_std_dev_unit_tb.sv
